@@ rtl/gcut_pkg.sv @@
// Shared types and constants of the GrowCut segmentation engine.
// Used by the attack unit, the square root unit and the top level.
package gcut_pkg;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_SEED = 2'd1,
        OP_PASS = 2'd2,
        OP_READ = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ME,
        ST_ME_W,
        ST_NB,
        ST_NB_W,
        ST_ATK,
        ST_WB
    } t_state;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    localparam int COLOR_W  = 24;
    localparam int STR_W    = 16;
    localparam int CFG_W    = 8;
    localparam int SQ_IN_W  = 26;
    localparam int SQ_OUT_W = 13;
    localparam int SQ_REM_W = 15;
    localparam int SUMSQ_W  = 18;

    localparam logic [13:0] G_SLOPE = 14'd9496;

    typedef logic signed [1:0] t_off;

    // Neighbor order: N, W, S, E, NW, NE, SW, SE.
    localparam t_off NB_DR [8] = '{-2'sd1, 2'sd0, 2'sd1, 2'sd0, -2'sd1, -2'sd1, 2'sd1, 2'sd1};
    localparam t_off NB_DC [8] = '{2'sd0, -2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1};

endpackage

@@ rtl/gcut_in_if.sv @@
// Request channel of the GrowCut engine: handshake plus one operation item.
// Depends on nothing.
interface gcut_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [6:0]  row;
    logic [6:0]  col;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [3:0]  seed_label;
    logic [15:0] seed_strength;

    modport source (output valid, operation, row, col, red, green, blue, seed_label,
                    seed_strength, input ready);
    modport sink (input valid, operation, row, col, red, green, blue, seed_label,
                  seed_strength, output ready);
endinterface

@@ rtl/gcut_out_if.sv @@
// Response channel of the GrowCut engine: handshake plus one result item.
// Depends on nothing.
interface gcut_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  cell_label;
    logic [15:0] cell_strength;
    logic        is_read_reply;

    modport source (output valid, cell_label, cell_strength, is_read_reply, input ready);
    modport sink (input valid, cell_label, cell_strength, is_read_reply, output ready);
endinterface

@@ rtl/gcut_isqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
// Depends on gcut_pkg for the operand widths.
module gcut_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [gcut_pkg::SQ_IN_W-1:0]  i_radicand,
    output logic                          o_done,
    output logic [gcut_pkg::SQ_OUT_W-1:0] o_root
);
    import gcut_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [3:0]           r_cnt, n_cnt;
    logic [SQ_IN_W-1:0]   r_rad, n_rad;
    logic [SQ_REM_W-1:0]  r_rem, n_rem;
    logic [SQ_OUT_W-1:0]  r_root, n_root;
    logic [SQ_REM_W+1:0]  rem_sh;
    logic [SQ_REM_W+1:0]  trial;

    always_comb begin
        rem_sh = {r_rem, r_rad[SQ_IN_W-1:SQ_IN_W-2]};
        trial  = {2'b00, r_root, 2'b01};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 4'(SQ_OUT_W - 1);
            n_rad  = i_radicand;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_rad = {r_rad[SQ_IN_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem  = SQ_REM_W'(rem_sh - trial);
                n_root = {r_root[SQ_OUT_W-2:0], 1'b1};
            end else begin
                n_rem  = SQ_REM_W'(rem_sh);
                n_root = {r_root[SQ_OUT_W-2:0], 1'b0};
            end
            if (r_cnt == 4'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

@@ rtl/gcut_attack.sv @@
// Attack strength of one neighbor: color distance, square root, falloff and scaling.
// Depends on gcut_pkg and gcut_isqrt.
module gcut_attack (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [gcut_pkg::COLOR_W-1:0] i_color_a,
    input  logic [gcut_pkg::COLOR_W-1:0] i_color_b,
    input  logic [gcut_pkg::STR_W-1:0]   i_strength,
    output logic                         o_done,
    output logic [gcut_pkg::STR_W-1:0]   o_attack
);
    import gcut_pkg::*;

    logic [7:0]            d_r, d_g, d_b;
    logic [SUMSQ_W-1:0]    sumsq;
    logic                  r_v1, r_v2, r_done;
    logic [SQ_IN_W-1:0]    r_rad;
    logic [STR_W-1:0]      r_s;
    logic [26:0]           r_prod;
    logic [STR_W-1:0]      r_att;
    logic                  sq_done;
    logic [SQ_OUT_W-1:0]   sq_root;
    logic [16:0]           drop;
    logic [STR_W-1:0]      g;
    logic [31:0]           scaled;

    always_comb begin
        d_r = (i_color_a[7:0] > i_color_b[7:0]) ? i_color_a[7:0] - i_color_b[7:0]
                                                : i_color_b[7:0] - i_color_a[7:0];
        d_g = (i_color_a[15:8] > i_color_b[15:8]) ? i_color_a[15:8] - i_color_b[15:8]
                                                  : i_color_b[15:8] - i_color_a[15:8];
        d_b = (i_color_a[23:16] > i_color_b[23:16]) ? i_color_a[23:16] - i_color_b[23:16]
                                                    : i_color_b[23:16] - i_color_a[23:16];
        sumsq = SUMSQ_W'(16'(d_r * d_r)) + SUMSQ_W'(16'(d_g * d_g))
              + SUMSQ_W'(16'(d_b * d_b));
        drop   = r_prod[26:10];
        g      = drop[16] ? '0 : 16'hFFFF - drop[15:0];
        scaled = 32'(g * r_s);
    end

    gcut_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_v1),
        .i_radicand (r_rad),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= sq_done;
            r_done <= r_v2;
        end
        if (i_start) begin
            r_rad <= {sumsq, 8'h00};
            r_s   <= i_strength;
        end
        if (sq_done) begin
            r_prod <= 27'(sq_root * G_SLOPE);
        end
        if (r_v2) begin
            r_att <= scaled[31:16];
        end
    end

    assign o_done   = r_done;
    assign o_attack = r_att;
endmodule

@@ rtl/growcut_segmentation_grid_top.sv @@
// GrowCut segmentation engine: color and cell memories with a pass sequencer.
// Load, seed and read stream one per cycle while the response channel accepts; a read answers next cycle.
// A pass walks the grid in raster order: per cell it reads the cell, tries its eight neighbor
// positions, runs the attack unit (13-step square root) on each in-grid one and writes back.
// After reset the cell memory is zeroed, one entry per cycle over every entry (MAX_ROWS * MAX_COLS,
// rounded to powers of two), during which no request is taken.
module growcut_segmentation_grid_top #(
    parameter int MAX_ROWS   = 128,
    parameter int MAX_COLS   = 128,
    parameter int LABEL_BITS = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [gcut_pkg::CFG_W-1:0] i_cfg_data,
    gcut_in_if.sink                    i_req,
    gcut_out_if.source                 o_rsp
);
    import gcut_pkg::*;

    localparam int RB    = $clog2(MAX_ROWS);
    localparam int CB    = $clog2(MAX_COLS);
    localparam int AW    = RB + CB;
    localparam int CELLS = 2 ** AW;
    localparam int CW    = LABEL_BITS + STR_W;

    logic [COLOR_W-1:0] r_color_mem [CELLS];
    logic [CW-1:0]      r_cell_mem [CELLS];

    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr, n_clr;
    logic [RB-1:0]      r_i, n_i;
    logic [CB-1:0]      r_j, n_j;
    logic [2:0]         r_k, n_k;
    logic [COLOR_W-1:0] r_me_color, n_me_color;
    logic [LABEL_BITS-1:0] r_cur_lab, n_cur_lab, r_nb_lab, n_nb_lab;
    logic [STR_W-1:0]   r_cur_str, n_cur_str;
    logic               r_ov, n_ov;
    logic               r_isread, n_isread;
    logic               r_inside, n_inside;
    logic [CFG_W-1:0]   r_rows, r_cols;
    logic [COLOR_W-1:0] r_col_q;
    logic [CW-1:0]      r_cell_q;

    logic [31:0]        rows32, cols32, nr32, nc32;
    logic [RB:0]        nr;
    logic [CB:0]        nc;
    logic [31:0]        row32, col32, lab32, seed32;
    logic               in_fire, in_inside;
    logic [AW-1:0]      in_addr, me_addr, nb_addr;
    logic signed [RB+1:0] nb_r;
    logic signed [CB+1:0] nb_c;
    logic               nb_in, last_col, last_row;
    t_op                op;

    logic               col_re, cell_re, cell_we, col_we;
    logic [AW-1:0]      col_ra, cell_ra, cell_wa;
    logic [CW-1:0]      cell_wd;
    logic               atk_start, atk_done;
    logic [STR_W-1:0]   atk_val;

    always_comb begin
        rows32 = 32'(r_rows);
        cols32 = 32'(r_cols);
        nr32 = (rows32 == 32'd0) ? 32'd1 : (rows32 > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : rows32;
        nc32 = (cols32 == 32'd0) ? 32'd1 : (cols32 > 32'(MAX_COLS)) ? 32'(MAX_COLS) : cols32;
        nr = nr32[RB:0];
        nc = nc32[CB:0];
        row32 = 32'(i_req.row);
        col32 = 32'(i_req.col);
        seed32 = 32'(i_req.seed_label);
        lab32 = 32'(r_cell_q[CW-1:STR_W]);
        in_inside = (row32 < nr32) && (col32 < nc32);
        in_addr = {row32[RB-1:0], col32[CB-1:0]};
        me_addr = {r_i, r_j};
        nb_r = $signed({2'b00, r_i}) + (RB+2)'(NB_DR[r_k]);
        nb_c = $signed({2'b00, r_j}) + (CB+2)'(NB_DC[r_k]);
        nb_in = !nb_r[RB+1] && !nb_c[CB+1] && (nb_r < $signed({1'b0, nr}))
             && (nb_c < $signed({1'b0, nc}));
        nb_addr = {nb_r[RB-1:0], nb_c[CB-1:0]};
        last_col = ({1'b0, r_j} == (CB+1)'(nc - 1'b1));
        last_row = ({1'b0, r_i} == (RB+1)'(nr - 1'b1));
        op = t_op'(i_req.operation);
        i_req.ready = (r_state == ST_IDLE) && (!r_ov || o_rsp.ready);
        in_fire = i_req.valid && i_req.ready;
    end

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_me_color = r_me_color;
        n_cur_lab  = r_cur_lab;
        n_cur_str  = r_cur_str;
        n_nb_lab   = r_nb_lab;
        n_ov       = r_ov && !o_rsp.ready;
        n_isread   = r_isread;
        n_inside   = r_inside;
        col_re     = 1'b0;
        col_ra     = in_addr;
        col_we     = 1'b0;
        cell_re    = 1'b0;
        cell_ra    = in_addr;
        cell_we    = 1'b0;
        cell_wa    = in_addr;
        cell_wd    = {seed32[LABEL_BITS-1:0], i_req.seed_strength};
        atk_start  = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                cell_we = 1'b1;
                cell_wa = r_clr;
                cell_wd = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == {AW{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    n_ov     = 1'b1;
                    n_isread = (op == OP_READ);
                    n_inside = in_inside;
                    cell_re  = 1'b1;
                    case (op)
                        OP_LOAD: col_we = in_inside;
                        OP_SEED: cell_we = in_inside;
                        OP_PASS: begin
                            n_i     = '0;
                            n_j     = '0;
                            n_state = ST_ME;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ME: begin
                col_re  = 1'b1;
                col_ra  = me_addr;
                cell_re = 1'b1;
                cell_ra = me_addr;
                n_state = ST_ME_W;
            end
            ST_ME_W: begin
                n_me_color = r_col_q;
                n_cur_lab  = r_cell_q[CW-1:STR_W];
                n_cur_str  = r_cell_q[STR_W-1:0];
                n_k        = 3'd0;
                n_state    = ST_NB;
            end
            ST_NB: begin
                if (nb_in) begin
                    col_re  = 1'b1;
                    col_ra  = nb_addr;
                    cell_re = 1'b1;
                    cell_ra = nb_addr;
                    n_state = ST_NB_W;
                end else if (r_k == 3'd7) begin
                    n_state = ST_WB;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            ST_NB_W: begin
                n_nb_lab  = r_cell_q[CW-1:STR_W];
                atk_start = 1'b1;
                n_state   = ST_ATK;
            end
            ST_ATK: begin
                if (atk_done) begin
                    if (atk_val > r_cur_str) begin
                        n_cur_lab = r_nb_lab;
                        n_cur_str = atk_val;
                    end
                    if (r_k == 3'd7) begin
                        n_state = ST_WB;
                    end else begin
                        n_k     = r_k + 3'd1;
                        n_state = ST_NB;
                    end
                end
            end
            ST_WB: begin
                cell_we = 1'b1;
                cell_wa = me_addr;
                cell_wd = {r_cur_lab, r_cur_str};
                n_state = ST_ME;
                if (last_col) begin
                    n_j = '0;
                    if (last_row) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    gcut_attack u_attack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (atk_start),
        .i_color_a  (r_me_color),
        .i_color_b  (r_col_q),
        .i_strength (r_cell_q[STR_W-1:0]),
        .o_done     (atk_done),
        .o_attack   (atk_val)
    );

    always_ff @(posedge i_clk) begin
        if (col_we) begin
            r_color_mem[in_addr] <= {i_req.blue, i_req.green, i_req.red};
        end
        if (col_re) begin
            r_col_q <= r_color_mem[col_ra];
        end
        if (cell_we) begin
            r_cell_mem[cell_wa] <= cell_wd;
        end
        if (cell_re) begin
            r_cell_q <= r_cell_mem[cell_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
            r_rows  <= CFG_W'(128);
            r_cols  <= CFG_W'(128);
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
            if (i_cfg_we && i_cfg_idx == CFG_ROWS) begin
                r_rows <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == CFG_COLS) begin
                r_cols <= i_cfg_data;
            end
        end
        r_i        <= n_i;
        r_j        <= n_j;
        r_k        <= n_k;
        r_me_color <= n_me_color;
        r_cur_lab  <= n_cur_lab;
        r_cur_str  <= n_cur_str;
        r_nb_lab   <= n_nb_lab;
        r_isread   <= n_isread;
        r_inside   <= n_inside;
    end

    assign o_rsp.valid         = r_ov;
    assign o_rsp.is_read_reply = r_isread;
    assign o_rsp.cell_label    = (r_isread && r_inside) ? lab32[3:0] : 4'd0;
    assign o_rsp.cell_strength = (r_isread && r_inside) ? r_cell_q[STR_W-1:0] : '0;
endmodule
